// File: rtl/core/zrlp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the per-byte parse step for the zone record line parser.
// No dependencies.
package zrlp_pkg;

  localparam int LINE_BUFFER_BYTES = 512;
  localparam int NAME_CAP_INT = ((LINE_BUFFER_BYTES - 2) < 510) ? (LINE_BUFFER_BYTES - 2) : 510;
  localparam logic [8:0]  NAME_CAP     = 9'(NAME_CAP_INT);
  localparam logic [8:0]  NAME_CNT_MAX = 9'd511;
  localparam logic [1:0]  DOT_CNT_MAX  = 2'd3;
  localparam logic [28:0] ALG_LIMIT    = 29'h1FF_FFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_LS    = 8'h73;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } zrlp_in_t;

  typedef struct packed {
    logic        record_valid;
    logic [8:0]  name_length;
    logic        is_ds_record;
    logic [28:0] algorithm_number;
  } zrlp_out_t;

  // input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    zrlp_in_t beat;
  } zrlp_slot_t;

  typedef enum logic [13:0] {
    PH_NAME       = 14'b00000000000001,
    PH_SP1        = 14'b00000000000010,
    PH_TTL        = 14'b00000000000100,
    PH_SP2        = 14'b00000000001000,
    PH_CLASS_N    = 14'b00000000010000,
    PH_CLASS_END  = 14'b00000000100000,
    PH_SP3        = 14'b00000001000000,
    PH_TYPE_S     = 14'b00000010000000,
    PH_TYPE_BLANK = 14'b00000100000000,
    PH_SP4        = 14'b00001000000000,
    PH_KEY        = 14'b00010000000000,
    PH_SP5        = 14'b00100000000000,
    PH_ALG        = 14'b01000000000000,
    PH_DONE       = 14'b10000000000000
  } zrlp_phase_t;

  typedef struct packed {
    zrlp_phase_t phase;
    logic [8:0]  name_cnt;
    logic [1:0]  dot_cnt;
    logic        err;
    logic        ds;
    logic [28:0] acc;
  } zrlp_state_t;

  localparam zrlp_state_t STATE_CLEAR = '{
    phase: PH_NAME, name_cnt: 9'd0, dot_cnt: 2'd0, err: 1'b0, ds: 1'b0, acc: 29'd0
  };

  // one byte of the line scanner
  function automatic zrlp_state_t zrlp_feed(zrlp_state_t s, logic [7:0] c);
    zrlp_state_t n;
    logic        blank;
    logic        digit;
    logic        namec;
    logic [28:0] dval;
    n     = s;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    digit = (c >= CH_0) && (c <= CH_9);
    namec = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) || digit ||
            (c == CH_DASH) || (c == CH_DOT);
    dval  = {21'd0, c - CH_0};
    if (!(s.err || (s.phase == PH_DONE))) begin
      case (s.phase)
        PH_NAME: begin
          if (namec) begin
            if (s.name_cnt < NAME_CNT_MAX) n.name_cnt = s.name_cnt + 9'd1;
            if ((c == CH_DOT) && (s.dot_cnt < DOT_CNT_MAX)) n.dot_cnt = s.dot_cnt + 2'd1;
          end else if ((s.name_cnt <= 9'd2) || (s.dot_cnt > 2'd1) || !blank) begin
            n.err = 1'b1;
          end else begin
            n.phase = PH_SP1;
          end
        end
        PH_SP1: begin
          if (digit) n.phase = PH_TTL;
          else if (!blank) n.err = 1'b1;
        end
        PH_TTL: begin
          if (blank) n.phase = PH_SP2;
          else if (!digit) n.err = 1'b1;
        end
        PH_SP2: begin
          if ((c == CH_LI) || (c == CH_UI)) n.phase = PH_CLASS_N;
          else if (!blank) n.err = 1'b1;
        end
        PH_CLASS_N: begin
          if ((c == CH_LN) || (c == CH_UN)) n.phase = PH_CLASS_END;
          else n.err = 1'b1;
        end
        PH_CLASS_END: begin
          if (blank) n.phase = PH_SP3;
          else n.err = 1'b1;
        end
        PH_SP3: begin
          if ((c == CH_LD) || (c == CH_UD)) n.phase = PH_TYPE_S;
          else if (!blank) n.phase = PH_DONE;
        end
        PH_TYPE_S: begin
          n.phase = ((c == CH_LS) || (c == CH_US)) ? PH_TYPE_BLANK : PH_DONE;
        end
        PH_TYPE_BLANK: begin
          if (blank) begin
            n.ds    = 1'b1;
            n.phase = PH_SP4;
          end else begin
            n.phase = PH_DONE;
          end
        end
        PH_SP4: begin
          if (digit) n.phase = PH_KEY;
          else if (!blank) n.err = 1'b1;
        end
        PH_KEY: begin
          if (blank) n.phase = PH_SP5;
          else if (!digit) n.err = 1'b1;
        end
        PH_SP5: begin
          if (digit) begin
            n.acc   = dval;
            n.phase = PH_ALG;
          end else if (!blank) begin
            n.err = 1'b1;
          end
        end
        PH_ALG: begin
          if (digit) begin
            // acc * 10 as two shifts; acc is at most ALG_LIMIT here so 29 bits hold it
            if (s.acc > ALG_LIMIT) n.err = 1'b1;
            else n.acc = (s.acc << 3) + (s.acc << 1) + dval;
          end else begin
            n.phase = PH_DONE;
          end
        end
        default: begin
          n.err = 1'b1;
        end
      endcase
    end
    return n;
  endfunction

endpackage

// File: rtl/core/zrlp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the zone record line parser: holds one byte beat.
// Depends on zrlp_pkg.
module zrlp_in_stage
  import zrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  zrlp_in_t   byte_data,
  input  logic       take,
  output zrlp_slot_t slot
);

  logic     held;
  zrlp_in_t beat;
  logic     load;

  assign load       = !held || take;
  assign byte_stall = held && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && byte_valid) begin
      beat <= byte_data;
    end
  end

  assign slot.valid = held;
  assign slot.beat  = beat;

endmodule

// File: rtl/core/zrlp_parser.sv
`timescale 1ns / 1ps
// Line scanner of the zone record line parser: per-line state and result forming.
// Depends on zrlp_pkg.
module zrlp_parser
  import zrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  zrlp_slot_t slot,
  input  logic       advance,
  output logic       take,
  output logic       done,
  output zrlp_out_t  result
);

  zrlp_state_t state;
  zrlp_state_t state_next;
  zrlp_state_t after_byte;
  zrlp_state_t after_term;
  logic        valid_line;
  logic [8:0]  len;

  // a last beat needs room in the output register, other beats only touch the state
  assign take = slot.valid && (advance || !slot.beat.end_of_line);
  assign done = take && slot.beat.end_of_line;

  assign after_byte = zrlp_feed(state, slot.beat.line_byte);
  assign after_term = zrlp_feed(after_byte, CH_NUL);

  always_comb begin
    state_next = state;
    if (take) begin
      state_next = slot.beat.end_of_line ? STATE_CLEAR : after_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    valid_line = !after_term.err && (after_term.phase == PH_DONE);
    len        = (after_term.name_cnt != 9'd0) ? after_term.name_cnt - 9'd1 : 9'd0;
    if (len > NAME_CAP) len = NAME_CAP;
    result.record_valid     = valid_line;
    result.name_length      = valid_line ? len : 9'd0;
    result.is_ds_record     = valid_line && after_term.ds;
    result.algorithm_number = (valid_line && after_term.ds) ? after_term.acc : 29'd0;
  end

endmodule

// File: rtl/core/zrlp_out_stage.sv
`timescale 1ns / 1ps
// Output register of the zone record line parser: holds one result beat.
// Depends on zrlp_pkg.
module zrlp_out_stage
  import zrlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      done,
  input  zrlp_out_t result,
  output logic      advance,
  output logic      rec_valid,
  input  logic      rec_stall,
  output zrlp_out_t rec_data
);

  assign advance = !rec_valid || !rec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (advance) begin
      rec_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && done) begin
      rec_data <= result;
    end
  end

endmodule

// File: rtl/core/zone_record_line_parser_core.sv
`timescale 1ns / 1ps
// Top level of the zone record line parser.
// Depends on zrlp_pkg, zrlp_in_stage, zrlp_parser, zrlp_out_stage.
//
// Usage:
//   The byte channel (byte_valid / byte_stall / byte_data) carries one character of a
//   zone file line per beat; end_of_line marks the final character of the line.
//   The record channel (rec_valid / rec_stall / rec_data) carries one result beat per
//   line: record_valid, name_length, is_ds_record and algorithm_number.
//   Throughput: one byte per cycle unless a line end waits for a stalled result; each
//   byte is one step of the line scanner, which sits between the input register and the output register.
//   A byte accepted into the input register is scanned as it is taken from there; for
//   the last byte of a line the result is registered in the output register as that
//   byte is taken and shows on rec_data from then on.
//   While rec_stall holds a result, bytes that do not end a line keep flowing; a
//   line end waits in the input register and byte_stall rises behind it.
//   Reset (rst, synchronous) empties both registers and returns the scanner to the
//   start of a line.
module zone_record_line_parser_core
  import zrlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  zrlp_in_t  byte_data,
  output logic      rec_valid,
  input  logic      rec_stall,
  output zrlp_out_t rec_data
);

  zrlp_slot_t slot;
  logic       take;
  logic       done;
  logic       advance;
  zrlp_out_t  result;

  zrlp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .take       (take),
    .slot       (slot)
  );

  zrlp_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .advance (advance),
    .take    (take),
    .done    (done),
    .result  (result)
  );

  zrlp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .result    (result),
    .advance   (advance),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data)
  );

endmodule

// File: rtl/core/zrlp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the zone record line parser, bound to the top level.
// Depends on zrlp_pkg and zone_record_line_parser_core.
module zrlp_checker
  import zrlp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      byte_valid,
  input logic      byte_stall,
  input zrlp_in_t  byte_data,
  input logic      rec_valid,
  input logic      rec_stall,
  input zrlp_out_t rec_data
);

  // an invalid line reports nothing else
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_data.record_valid |->
      rec_data.name_length == 9'd0 && !rec_data.is_ds_record &&
      rec_data.algorithm_number == 29'd0)
    else $error("invalid line carries nonzero fields");

  a_alg_needs_ds: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_data.is_ds_record |-> rec_data.algorithm_number == 29'd0)
    else $error("algorithm number without DS type");

  // owner name has at least three characters, length is capped
  a_name_range: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_data.record_valid |->
      rec_data.name_length >= 9'd2 && rec_data.name_length <= NAME_CAP)
    else $error("name length out of range");

  // a result beat needs an earlier accepted line-ending byte beat
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rec_valid) && !$past(rst) && !$past(rst, 2) |->
      $past(byte_valid && !byte_stall && byte_data.end_of_line, 2) || $past(byte_stall, 1))
    else $error("result beat without a line end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_stall |=> rec_valid && $stable(rec_data))
    else $error("stalled result beat changed");

endmodule

bind zone_record_line_parser_core zrlp_checker u_zrlp_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_data  (byte_data),
  .rec_valid  (rec_valid),
  .rec_stall  (rec_stall),
  .rec_data   (rec_data)
);
